// ----- rtl/lcel_pkg.sv -----
// ----------------------------------------------------------------------------
// lcel_pkg
// Shared types and constants of the labeled CSR edge lookup engine.
// ----------------------------------------------------------------------------
package lcel_pkg;

	localparam int VERT_W  = 12;
	localparam int LABEL_W = 8;
	localparam int IDX_W   = 16;
	localparam int VAL_W   = 17;

	localparam logic [2:0] CMD_VOFF = 3'd0;
	localparam logic [2:0] CMD_LAB  = 3'd1;
	localparam logic [2:0] CMD_LOFF = 3'd2;
	localparam logic [2:0] CMD_NBR  = 3'd3;
	localparam logic [2:0] CMD_ADJ  = 3'd4;
	localparam logic [2:0] CMD_EDGE = 3'd5;
	localparam logic [2:0] CMD_NOP  = 3'd6;

	localparam int VOFF_ENTRIES = 4097;
	localparam int LAB_ENTRIES  = 16384;
	localparam int LOFF_ENTRIES = 16385;

	localparam logic [VAL_W-1:0] MAX_LABEL_SLOTS = 17'd16384;
	localparam logic [VAL_W-1:0] MAX_NEIGHBORS   = 17'd65536;

	typedef struct packed {
		logic [2:0]         kind;
		logic               dir;
		logic               wr_ok;
		logic [IDX_W-1:0]   wr_idx;
		logic [VAL_W-1:0]   wr_val;
		logic [VERT_W-1:0]  u;
		logic [VERT_W-1:0]  v;
		logic [LABEL_W-1:0] el;
	} item_t;

endpackage

// ----- rtl/lcel_front.sv -----
// ----------------------------------------------------------------------------
// lcel_front
// Accepts input words, classifies the command and prepares stored values.
// ----------------------------------------------------------------------------
module lcel_front import lcel_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic               direction,
	input  logic [IDX_W-1:0]   write_index,
	input  logic [VAL_W-1:0]   write_value,
	input  logic [VERT_W-1:0]  first_vertex,
	input  logic [VERT_W-1:0]  second_vertex,
	input  logic [LABEL_W-1:0] edge_label,
	input  logic               q_full,
	output logic               q_push,
	output item_t              q_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;
	logic  load;

	always_comb begin
		item_d        = '0;
		item_d.kind   = command;
		item_d.dir    = direction;
		item_d.wr_idx = write_index;
		item_d.u      = first_vertex;
		item_d.v      = second_vertex;
		item_d.el     = edge_label;
		unique case (command)
			CMD_VOFF: begin
				item_d.wr_ok  = ({1'b0, write_index} < VOFF_ENTRIES[IDX_W:0]);
				item_d.wr_val = (write_value > MAX_LABEL_SLOTS) ? MAX_LABEL_SLOTS
					: write_value;
			end
			CMD_LAB: begin
				item_d.wr_ok  = ({1'b0, write_index} < LAB_ENTRIES[IDX_W:0]);
				item_d.wr_val = {{(VAL_W-LABEL_W){1'b0}}, write_value[LABEL_W-1:0]};
			end
			CMD_LOFF: begin
				item_d.wr_ok  = ({1'b0, write_index} < LOFF_ENTRIES[IDX_W:0]);
				item_d.wr_val = (write_value > MAX_NEIGHBORS) ? MAX_NEIGHBORS
					: write_value;
			end
			CMD_NBR: begin
				item_d.wr_ok  = 1'b1;
				item_d.wr_val = {{(VAL_W-VERT_W){1'b0}}, write_value[VERT_W-1:0]};
			end
			CMD_ADJ, CMD_EDGE: begin
				item_d.wr_ok = 1'b0;
			end
			default: begin
				item_d.kind = CMD_NOP;
			end
		endcase
	end

	assign q_push   = valid_s1 && !q_full;
	assign q_item   = item_s1;
	assign in_stall = valid_s1 && q_full;
	assign load     = !valid_s1 || q_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ----- rtl/lcel_queue.sv -----
// ----------------------------------------------------------------------------
// lcel_queue
// Four-entry queue of classified words between the front and back parts.
// ----------------------------------------------------------------------------
module lcel_queue import lcel_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output item_t head
);

	item_t      slot_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	assign full  = (count_q == 3'd4);
	assign empty = (count_q == 3'd0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (push && !pop) begin
				count_q <= count_q + 3'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/lcel_back.sv -----
// ----------------------------------------------------------------------------
// lcel_back
// Holds the graph tables and runs the load and binary search sequence.
// ----------------------------------------------------------------------------
module lcel_back import lcel_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  item_t              q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [LABEL_W-1:0] label_rank,
	output logic [VAL_W-1:0]   neighbor_start,
	output logic [VAL_W-1:0]   neighbor_count
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_WR   = 4'd1;
	localparam logic [3:0] ST_V0   = 4'd2;
	localparam logic [3:0] ST_V1   = 4'd3;
	localparam logic [3:0] ST_V2   = 4'd4;
	localparam logic [3:0] ST_LS   = 4'd5;
	localparam logic [3:0] ST_LC   = 4'd6;
	localparam logic [3:0] ST_LH   = 4'd7;
	localparam logic [3:0] ST_O1   = 4'd8;
	localparam logic [3:0] ST_O2   = 4'd9;
	localparam logic [3:0] ST_LD   = 4'd10;
	localparam logic [3:0] ST_NS   = 4'd11;
	localparam logic [3:0] ST_NSR  = 4'd12;
	localparam logic [3:0] ST_NC   = 4'd13;
	localparam logic [3:0] ST_NH   = 4'd14;
	localparam logic [3:0] ST_OUT  = 4'd15;

	logic [14:0]  voff_mem [2**14];
	logic [7:0]   lab_mem  [2**15];
	logic [16:0]  loff_mem [2**16];
	logic [11:0]  nbr_mem  [2**17];

	logic [14:0]  voff_rd;
	logic [7:0]   lab_rd;
	logic [16:0]  loff_rd;
	logic [11:0]  nbr_rd;
	logic [13:0]  voff_ra;
	logic [14:0]  lab_ra;
	logic [15:0]  loff_ra;
	logic [16:0]  nbr_ra;

	logic [3:0]   state_q;
	item_t        item_q;
	logic         phase_q;
	logic         dir_q;
	logic [11:0]  vert_q;
	logic [14:0]  b_q;
	logic [16:0]  lo_q;
	logic [16:0]  hi_q;
	logic [16:0]  end_q;
	logic [16:0]  s0_q;
	logic [16:0]  us_q;
	logic [16:0]  uc_q;
	logic         ld_q;
	logic [11:0]  key_q;
	logic         res_found_q;
	logic [7:0]   res_rank_q;
	logic [16:0]  res_start_q;
	logic [16:0]  res_count_q;
	logic         out_valid_q;
	logic         found_q;
	logic [7:0]   rank_q;
	logic [16:0]  start_q;
	logic [16:0]  count_q;

	logic [16:0]  mid;
	logic         more;
	logic [16:0]  probe;
	logic         use_u;
	logic [16:0]  sel_s;
	logic [16:0]  sel_c;
	logic [16:0]  ls;
	logic [17:0]  le_sum;
	logic [16:0]  le;
	logic         wr_en;

	assign mid   = lo_q + ((hi_q - lo_q) >> 1);
	assign more  = (lo_q < hi_q);
	assign probe = more ? mid : lo_q;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign wr_en = (state_q == ST_WR) && item_q.wr_ok;

	assign use_u  = (uc_q < res_count_q);
	assign sel_s  = use_u ? us_q : res_start_q;
	assign sel_c  = use_u ? uc_q : res_count_q;
	assign ls     = (sel_s > MAX_NEIGHBORS) ? MAX_NEIGHBORS : sel_s;
	assign le_sum = {1'b0, ls} + {1'b0, sel_c};
	assign le     = ((MAX_NEIGHBORS - ls) < sel_c) ? MAX_NEIGHBORS : le_sum[16:0];

	always_comb begin
		voff_ra = '0;
		lab_ra  = '0;
		loff_ra = '0;
		nbr_ra  = '0;
		unique case (state_q)
			ST_V0: voff_ra = {dir_q, 1'b0, vert_q};
			ST_V1: voff_ra = {dir_q, {1'b0, vert_q} + 13'd1};
			ST_LS: lab_ra  = {dir_q, probe[13:0]};
			ST_LH: loff_ra = {dir_q, lo_q[14:0]};
			ST_O1: loff_ra = {dir_q, lo_q[14:0] + 15'd1};
			ST_NSR: nbr_ra = {ld_q, probe[15:0]};
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en && item_q.kind == CMD_VOFF) begin
			voff_mem[{item_q.dir, item_q.wr_idx[12:0]}] <= item_q.wr_val[14:0];
		end
		voff_rd <= voff_mem[voff_ra];
	end

	always_ff @(posedge clk) begin
		if (wr_en && item_q.kind == CMD_LAB) begin
			lab_mem[{item_q.dir, item_q.wr_idx[13:0]}] <= item_q.wr_val[7:0];
		end
		lab_rd <= lab_mem[lab_ra];
	end

	always_ff @(posedge clk) begin
		if (wr_en && item_q.kind == CMD_LOFF) begin
			loff_mem[{item_q.dir, item_q.wr_idx[14:0]}] <= item_q.wr_val;
		end
		loff_rd <= loff_mem[loff_ra];
	end

	always_ff @(posedge clk) begin
		if (wr_en && item_q.kind == CMD_NBR) begin
			nbr_mem[{item_q.dir, item_q.wr_idx}] <= item_q.wr_val[11:0];
		end
		nbr_rd <= nbr_mem[nbr_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (q_head.kind == CMD_ADJ || q_head.kind == CMD_EDGE) begin
							state_q <= ST_V0;
						end else begin
							state_q <= ST_WR;
						end
					end
				end
				ST_WR: state_q <= ST_OUT;
				ST_V0: state_q <= ST_V1;
				ST_V1: state_q <= ST_V2;
				ST_V2: state_q <= ({2'b0, voff_rd} <= {2'b0, b_q}) ? ST_LD : ST_LS;
				ST_LS: begin
					if (more) begin
						state_q <= ST_LC;
					end else if (lo_q < end_q) begin
						state_q <= ST_LH;
					end else begin
						state_q <= ST_LD;
					end
				end
				ST_LC: state_q <= ST_LS;
				ST_LH: state_q <= (lab_rd == item_q.el) ? ST_O1 : ST_LD;
				ST_O1: state_q <= ST_O2;
				ST_O2: state_q <= ST_LD;
				ST_LD: begin
					if (item_q.kind == CMD_ADJ) begin
						state_q <= ST_OUT;
					end else if (!phase_q) begin
						state_q <= ST_V0;
					end else begin
						state_q <= ST_NS;
					end
				end
				ST_NS: state_q <= ST_NSR;
				ST_NSR: begin
					if (more) begin
						state_q <= ST_NC;
					end else if (lo_q < end_q) begin
						state_q <= ST_NH;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_NC: state_q <= ST_NSR;
				ST_NH: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q  <= q_head;
				phase_q <= 1'b0;
				dir_q   <= q_head.dir;
				vert_q  <= q_head.u;
			end
			ST_WR: begin
				res_found_q <= 1'b0;
				res_rank_q  <= '0;
				res_start_q <= '0;
				res_count_q <= '0;
			end
			ST_V1: b_q <= voff_rd;
			ST_V2: begin
				lo_q        <= {2'b0, b_q};
				hi_q        <= {2'b0, voff_rd};
				end_q       <= {2'b0, voff_rd};
				res_found_q <= 1'b0;
				res_rank_q  <= '0;
				res_start_q <= '0;
				res_count_q <= '0;
			end
			ST_LC, ST_NC: begin
				if ((state_q == ST_LC) ? (lab_rd < item_q.el) : (nbr_rd < key_q)) begin
					lo_q <= mid + 17'd1;
				end else begin
					hi_q <= mid;
				end
			end
			ST_O1: s0_q <= loff_rd;
			ST_O2: begin
				res_found_q <= 1'b1;
				res_rank_q  <= lo_q[7:0] - b_q[7:0];
				res_start_q <= s0_q;
				res_count_q <= (loff_rd > s0_q) ? loff_rd - s0_q : '0;
			end
			ST_LD: begin
				if (!phase_q) begin
					us_q    <= res_start_q;
					uc_q    <= res_count_q;
					phase_q <= 1'b1;
					dir_q   <= !item_q.dir;
					vert_q  <= item_q.v;
				end
			end
			ST_NS: begin
				ld_q        <= use_u ? item_q.dir : !item_q.dir;
				key_q       <= use_u ? item_q.v : item_q.u;
				lo_q        <= ls;
				hi_q        <= le;
				end_q       <= le;
				res_found_q <= 1'b0;
				res_rank_q  <= '0;
				res_start_q <= '0;
				res_count_q <= '0;
			end
			ST_NH: res_found_q <= (nbr_rd == key_q);
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					found_q <= res_found_q;
					rank_q  <= res_rank_q;
					start_q <= res_start_q;
					count_q <= res_count_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign label_rank     = rank_q;
	assign neighbor_start = start_q;
	assign neighbor_count = count_q;

endmodule

// ----- rtl/labeled_csr_edge_lookup.sv -----
// ----------------------------------------------------------------------------
// labeled_csr_edge_lookup
// Lookup engine over a labeled compressed-sparse-row graph in two directions.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid / in_stall and carry one command: a load of
// a vertex offset, a label, a label offset or a neighbor id, an adjacency
// query, or an edge query. Every word yields exactly one result word on
// out_valid / out_stall, in order. The front registers and classifies words
// and places them in a four-entry queue, so it keeps taking words while the
// back part is busy, until the queue is full. The back part holds all tables
// in memories and runs one word at a time. A load writes its table entry if
// the index is in range and then raises out_valid. An adjacency query reads
// two vertex offsets, binary searches the vertex's labels and, on a match,
// reads the label offsets. An edge query runs two such label searches and
// then a search of the shorter neighbor list. Every table read is registered,
// so each search step takes a probe state and a compare state.
// Reset clears the control state and the queue; table contents are not
// cleared and must be loaded before use. While out_stall is high the result
// word is held and the back part waits once its next result is ready.
// ----------------------------------------------------------------------------
module labeled_csr_edge_lookup import lcel_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic               direction,
	input  logic [IDX_W-1:0]   write_index,
	input  logic [VAL_W-1:0]   write_value,
	input  logic [VERT_W-1:0]  first_vertex,
	input  logic [VERT_W-1:0]  second_vertex,
	input  logic [LABEL_W-1:0] edge_label,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [LABEL_W-1:0] label_rank,
	output logic [VAL_W-1:0]   neighbor_start,
	output logic [VAL_W-1:0]   neighbor_count
);

	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_empty;
	item_t q_item;
	item_t q_head;

	lcel_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.direction     (direction),
		.write_index   (write_index),
		.write_value   (write_value),
		.first_vertex  (first_vertex),
		.second_vertex (second_vertex),
		.edge_label    (edge_label),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_item)
	);

	lcel_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	lcel_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.found          (found),
		.label_rank     (label_rank),
		.neighbor_start (neighbor_start),
		.neighbor_count (neighbor_count)
	);

endmodule
